[sv/btbp_pkg.sv]
// btbp_pkg: shared constants for the two-level branch predictor
`timescale 1ns / 1ps
package btbp_pkg;

  localparam int unsigned TagW  = 30;  // widest tag, bits of pc>>2
  localparam int unsigned CtrW  = 2;   // two-bit saturating counter
  localparam int unsigned CfgIW = 3;   // configuration index width
  localparam int unsigned CfgDW = 5;   // widest configuration register

  localparam logic [CfgIW-1:0] CFG_BTB_INDEX_BITS = 3'd0;
  localparam logic [CfgIW-1:0] CFG_HISTORY_BITS   = 3'd1;
  localparam logic [CfgIW-1:0] CFG_TAG_BITS       = 3'd2;
  localparam logic [CfgIW-1:0] CFG_DEFAULT_STATE  = 3'd3;
  localparam logic [CfgIW-1:0] CFG_GLOBAL_HISTORY = 3'd4;
  localparam logic [CfgIW-1:0] CFG_GLOBAL_TABLE   = 3'd5;
  localparam logic [CfgIW-1:0] CFG_SHARE_MODE     = 3'd6;

  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_UPDATE  = 1'b1;

  localparam logic [1:0] SHARE_HIST  = 2'd0;
  localparam logic [1:0] SHARE_LOWPC = 2'd1;
  localparam logic [1:0] SHARE_PC16  = 2'd2;

  localparam logic [CtrW-1:0] CTR_MAX       = 2'd3;
  localparam logic [CtrW-1:0] CTR_MIN       = 2'd0;
  localparam logic [CtrW-1:0] CTR_TAKEN_THR = 2'd2;
  localparam logic [CtrW-1:0] CTR_RESET     = 2'd1;

  localparam logic [4:0] TAG_BITS_MAX = 5'd30;

endpackage

[sv/btbp_ram.sv]
// btbp_ram: single-port-write, single-port-read synchronous memory
`timescale 1ns / 1ps
module btbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/btbp_mod.sv]
// btbp_mod: remainder of a tag by the constant table depth, by reciprocal multiplication
`timescale 1ns / 1ps
module btbp_mod #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IN_W  = 30,
  parameter int unsigned OUT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IN_W-1:0]  value_i,
  output logic             done_o,
  output logic [OUT_W-1:0] rem_o
);

  // quotient = (value * Recip) >> Shift is exact for every value below 2^IN_W
  localparam int unsigned Shift = IN_W + $clog2(DEPTH);
  localparam int unsigned MulW  = IN_W + 1;
  localparam int unsigned ProdW = IN_W + MulW;
  localparam logic [63:0] RecipW = ((64'd1 << Shift) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam logic [MulW-1:0] Recip = RecipW[MulW-1:0];

  logic             s1_q, s2_q, done_q;
  logic [IN_W-1:0]  val_q;
  logic [ProdW-1:0] prod_q;
  logic [OUT_W-1:0] rem_q;
  logic [IN_W-1:0]  quot;
  logic [IN_W-1:0]  rem_full;

  always_comb begin
    quot     = IN_W'(prod_q >> Shift);
    rem_full = val_q - IN_W'(quot * IN_W'(DEPTH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  // capture, multiply by the reciprocal, then subtract the quotient multiple
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end
    if (s1_q) begin
      prod_q <= ProdW'(val_q) * ProdW'(Recip);
    end
    if (s2_q) begin
      rem_q <= rem_full[OUT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[sv/btb_two_level_branch_predictor_core.sv]
// btb_two_level_branch_predictor_core: btb with two-level direction prediction
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------------
//  command  | in        | start & !busy            | action, pc, target_pc, taken,
//           |           |                          | predicted_target
//  result   | out       | done_o, one-cycle strobe | pred_taken, pred_target,
//           |           |                          | branch_count, flush_count
//  config   | in        | cfg_valid_i & cfg_ready_o| cfg_index_i, cfg_data_i
//
// for an item the accept edge reads the entry memory and the counter row memory,
// the next cycle modifies and writes back and the result strobe follows on the
// cycle after; a new item may be accepted in that cycle
// when the depth is not a power of two and the entry count saturates, the index
// comes from a reciprocal-multiply remainder unit and the reads wait for its remainder
// reset clears valid bits, history, counts and loads the shared counters with
// the reset default state; no clearing pass is run
// results cannot be stalled, so nothing waits on the receiver
`timescale 1ns / 1ps
module btb_two_level_branch_predictor_core
  import btbp_pkg::*;
#(
  parameter int unsigned BTB_DEPTH  = 32,
  parameter int unsigned HIST_MAX   = 8,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action_i,
  input  logic [ADDR_WIDTH-1:0] pc_i,
  input  logic [ADDR_WIDTH-1:0] target_pc_i,
  input  logic                  taken_i,
  input  logic [ADDR_WIDTH-1:0] predicted_target_i,
  output logic                  done_o,
  output logic                  pred_taken_o,
  output logic [31:0]           pred_target_o,
  output logic [31:0]           branch_count_o,
  output logic [31:0]           flush_count_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIW-1:0]      cfg_index_i,
  input  logic [CfgDW-1:0]      cfg_data_i
);

  localparam int unsigned IdxW      = (BTB_DEPTH > 1) ? $clog2(BTB_DEPTH) : 1;
  localparam int unsigned RowAw     = $clog2(BTB_DEPTH + 1);
  localparam int unsigned RowW      = CtrW << HIST_MAX;
  localparam int unsigned EntW      = HIST_MAX + TagW + ADDR_WIDTH;
  localparam bit          DepthPow2 = (BTB_DEPTH & (BTB_DEPTH - 1)) == 0;
  localparam logic [RowAw-1:0] SharedRow = RowAw'(BTB_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  // configuration registers
  logic [2:0] cfg_bib_q;
  logic [3:0] cfg_hb_q;
  logic [4:0] cfg_tb_q;
  logic [1:0] cfg_ds_q;
  logic       cfg_gh_q;
  logic       cfg_gt_q;
  logic [1:0] cfg_sm_q;

  // shared counter row is lazily filled after reset or a default-state write
  logic            shr_ok_q;
  logic [CtrW-1:0] shr_fill_q;

  logic [1:0]      state_q, state_d;
  logic            accept;
  logic            cfg_wr;

  // latched command
  logic                  act_q, tkn_q;
  logic [ADDR_WIDTH-1:0] pc_q, tgt_q, pdst_q;
  logic [TagW-1:0]       tag_q;
  logic [IdxW-1:0]       idx_q;

  logic [BTB_DEPTH-1:0]  valid_q, hok_q;
  logic [HIST_MAX-1:0]   shist_q;
  logic [31:0]           branches_q, flushes_q;
  logic                  done_q, ptaken_q;
  logic [31:0]           ptarget_q;

  // index generation
  logic [63:0]     pc_in_x;
  logic [4:0]      tb;
  logic [30:0]     tmask;
  logic [TagW-1:0] tag_in;
  logic [8:0]      ents, idx_mask;
  logic            sat, need_mod;
  logic [IdxW-1:0] idx_fast;
  logic            mod_done;
  logic [IdxW-1:0] mod_rem;

  // memory ports
  logic             ent_rd_en, row_rd_en;
  logic [IdxW-1:0]  ent_rd_addr;
  logic [RowAw-1:0] row_rd_addr;
  logic [EntW-1:0]  ent_rd_data, ent_wr_data;
  logic [RowW-1:0]  row_rd_data, row_wr_data;
  logic             mem_wr;
  logic [RowAw-1:0] row_wr_addr;

  // execute stage
  logic [ADDR_WIDTH-1:0] ent_tgt, next_pc;
  logic [TagW-1:0]       ent_tag;
  logic [HIST_MAX-1:0]   ent_hist, hist_cur, hist_eff, hmask, share, cidx, new_hist;
  logic [HIST_MAX:0]     hmask_w;
  logic [3:0]            hw;
  logic [63:0]           pc_x, next_x, tgt_x;
  logic                  hit, alloc, mispred;
  logic [RowW-1:0]       row_in;
  logic [CtrW-1:0]       ctr, new_ctr;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign busy        = (state_q != S_IDLE);

  // tag and entry index of the incoming pc
  always_comb begin
    pc_in_x  = 64'(pc_i);
    tb       = (cfg_tb_q > TAG_BITS_MAX) ? TAG_BITS_MAX : cfg_tb_q;
    tmask    = (31'(1) << tb) - 31'(1);
    tag_in   = pc_in_x[31:2] & tmask[TagW-1:0];
    ents     = 9'(1) << cfg_bib_q;
    sat      = ents > 9'(BTB_DEPTH);
    need_mod = !DepthPow2 && sat;
    idx_mask = sat ? 9'(BTB_DEPTH - 1) : ents - 9'(1);
    idx_fast = IdxW'(tag_in[8:0] & idx_mask);
  end

  btbp_mod #(
    .DEPTH (BTB_DEPTH),
    .IN_W  (TagW),
    .OUT_W (IdxW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && need_mod),
    .value_i (tag_in),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // reads issued at accept, or once the remainder is known
  always_comb begin
    ent_rd_en   = (accept && !need_mod) || mod_done;
    row_rd_en   = ent_rd_en;
    ent_rd_addr = (state_q == S_IDLE) ? idx_fast : mod_rem;
    row_rd_addr = cfg_gt_q ? SharedRow : RowAw'(ent_rd_addr);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = need_mod ? S_MOD : S_EXEC;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  btbp_ram #(
    .WIDTH (EntW),
    .DEPTH (BTB_DEPTH),
    .AW    (IdxW)
  ) u_ent_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ent_rd_en),
    .rd_addr_i (ent_rd_addr),
    .rd_data_o (ent_rd_data),
    .wr_en_i   (mem_wr),
    .wr_addr_i (idx_q),
    .wr_data_i (ent_wr_data)
  );

  // per-entry counter rows plus one row for the shared table
  btbp_ram #(
    .WIDTH (RowW),
    .DEPTH (BTB_DEPTH + 1),
    .AW    (RowAw)
  ) u_row_ram (
    .clk_i     (clk_i),
    .rd_en_i   (row_rd_en),
    .rd_addr_i (row_rd_addr),
    .rd_data_o (row_rd_data),
    .wr_en_i   (mem_wr),
    .wr_addr_i (row_wr_addr),
    .wr_data_i (row_wr_data)
  );

  // read-modify-write of the entry and its counter
  always_comb begin
    {ent_hist, ent_tag, ent_tgt} = ent_rd_data;
    pc_x     = 64'(pc_q);
    next_pc  = pc_q + ADDR_WIDTH'(4);
    next_x   = 64'(next_pc);
    tgt_x    = 64'(ent_tgt);
    hw       = (cfg_hb_q == 4'd0) ? 4'd1 :
               ((cfg_hb_q > 4'(HIST_MAX)) ? 4'(HIST_MAX) : cfg_hb_q);
    hmask_w  = ((HIST_MAX+1)'(1) << hw) - (HIST_MAX+1)'(1);
    hmask    = hmask_w[HIST_MAX-1:0];
    hit      = valid_q[idx_q] && (ent_tag == tag_q);
    alloc    = (act_q == ACT_UPDATE) && !hit;
    hist_cur = cfg_gh_q ? shist_q : (hok_q[idx_q] ? ent_hist : '0);
    // allocation clears a per-entry history before the counter lookup
    hist_eff = ((alloc && !cfg_gh_q) ? '0 : hist_cur) & hmask;
    share    = '0;
    if (cfg_gt_q) begin
      priority if (cfg_sm_q == SHARE_LOWPC) begin
        share = pc_x[2 +: HIST_MAX] & hmask;
      end else if (cfg_sm_q == SHARE_PC16) begin
        share = pc_x[16 +: HIST_MAX] & hmask;
      end else begin
        share = '0;
      end
    end
    cidx = (hist_eff ^ share) & hmask;
    if (cfg_gt_q) begin
      row_in = shr_ok_q ? row_rd_data : {(1 << HIST_MAX){shr_fill_q}};
    end else begin
      row_in = alloc ? {(1 << HIST_MAX){cfg_ds_q}} : row_rd_data;
    end
    ctr = row_in[{cidx, 1'b0} +: CtrW];
    if (tkn_q) begin
      new_ctr = (ctr == CTR_MAX) ? ctr : ctr + CtrW'(1);
    end else begin
      new_ctr = (ctr == CTR_MIN) ? ctr : ctr - CtrW'(1);
    end
    row_wr_data = row_in;
    row_wr_data[{cidx, 1'b0} +: CtrW] = new_ctr;
    row_wr_addr = cfg_gt_q ? SharedRow : RowAw'(idx_q);
    new_hist    = {hist_eff[HIST_MAX-2:0] & hmask[HIST_MAX-2:0], tkn_q} & hmask;
    ent_wr_data = {(cfg_gh_q ? ent_hist : new_hist), tag_q, tgt_q};
    mem_wr      = (state_q == S_EXEC) && (act_q == ACT_UPDATE);
    mispred     = !((tkn_q && tgt_q == pdst_q) || (!tkn_q && pdst_q == next_pc));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cfg_bib_q  <= '0;
      cfg_hb_q   <= 4'd1;
      cfg_tb_q   <= '0;
      cfg_ds_q   <= CTR_RESET;
      cfg_gh_q   <= 1'b0;
      cfg_gt_q   <= 1'b0;
      cfg_sm_q   <= SHARE_HIST;
      shr_ok_q   <= 1'b0;
      shr_fill_q <= CTR_RESET;
      valid_q    <= '0;
      hok_q      <= '0;
      shist_q    <= '0;
      branches_q <= '0;
      flushes_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_EXEC);
      if (cfg_wr) begin
        unique case (cfg_index_i)
          CFG_BTB_INDEX_BITS: cfg_bib_q <= cfg_data_i[2:0];
          CFG_HISTORY_BITS:   cfg_hb_q  <= cfg_data_i[3:0];
          CFG_TAG_BITS:       cfg_tb_q  <= cfg_data_i;
          CFG_DEFAULT_STATE: begin
            cfg_ds_q   <= cfg_data_i[1:0];
            shr_fill_q <= cfg_data_i[1:0];
            shr_ok_q   <= 1'b0;
          end
          CFG_GLOBAL_HISTORY: cfg_gh_q  <= cfg_data_i[0];
          CFG_GLOBAL_TABLE:   cfg_gt_q  <= cfg_data_i[0];
          CFG_SHARE_MODE:     cfg_sm_q  <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (mem_wr) begin
        valid_q[idx_q] <= 1'b1;
        branches_q     <= branches_q + 32'd1;
        if (mispred) begin
          flushes_q <= flushes_q + 32'd1;
        end
        if (cfg_gt_q) begin
          shr_ok_q <= 1'b1;
        end
        if (cfg_gh_q) begin
          shist_q <= new_hist;
        end else begin
          hok_q[idx_q] <= 1'b1;
        end
      end
    end
  end

  // command capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_i;
      pc_q   <= pc_i;
      tgt_q  <= target_pc_i;
      tkn_q  <= taken_i;
      pdst_q <= predicted_target_i;
      tag_q  <= tag_in;
      idx_q  <= idx_fast;
    end else if (mod_done) begin
      idx_q <= mod_rem;
    end
    if (state_q == S_EXEC) begin
      if (act_q == ACT_UPDATE) begin
        ptaken_q  <= 1'b0;
        ptarget_q <= '0;
      end else if (hit && ctr >= CTR_TAKEN_THR) begin
        ptaken_q  <= 1'b1;
        ptarget_q <= tgt_x[31:0];
      end else begin
        ptaken_q  <= 1'b0;
        ptarget_q <= next_x[31:0];
      end
    end
  end

  assign done_o         = done_q;
  assign pred_taken_o   = ptaken_q;
  assign pred_target_o  = ptarget_q;
  assign branch_count_o = branches_q;
  assign flush_count_o  = flushes_q;

endmodule

[sv/btbp_checker.sv]
// btbp_checker: port-level assertions for the predictor core, bound to the top
`timescale 1ns / 1ps
module btbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] branch_count_o,
  input logic [31:0] flush_count_o
);

  // an accepted command always occupies the core in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not make the core busy");

  // a result strobe only ends a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result without a preceding busy cycle");

  // counts move only with a result transfer, by at most one
  a_branch_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(branch_count_o))
    else $error("branch count changed without a result");

  a_flush_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (flush_count_o == $past(flush_count_o)) ||
               (flush_count_o == $past(flush_count_o) + 32'd1 &&
                branch_count_o == $past(branch_count_o) + 32'd1))
    else $error("flush count moved without a counted update");

endmodule

bind btb_two_level_branch_predictor_core btbp_checker u_btbp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .branch_count_o (branch_count_o),
  .flush_count_o  (flush_count_o)
);

[sim/tb_btb_two_level_branch_predictor_core.sv]
// tb_btb_two_level_branch_predictor_core: self-checking testbench for the branch predictor core
`timescale 1ns / 1ps
module tb_btb_two_level_branch_predictor_core;
  import btbp_pkg::*;

  typedef struct {
    logic        action;
    logic [31:0] pc;
    logic [31:0] target_pc;
    logic        taken;
    logic [31:0] predicted_target;
  } branch_cmd_t;

  typedef struct {
    logic        pred_taken;
    logic [31:0] pred_target;
    logic [31:0] branch_count;
    logic [31:0] flush_count;
  } branch_res_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // block ports, all inputs driven from time zero
  logic              start = 1'b0;
  logic              busy;
  logic              action_i = ACT_PREDICT;
  logic [31:0]       pc_i = '0;
  logic [31:0]       target_pc_i = '0;
  logic              taken_i = 1'b0;
  logic [31:0]       predicted_target_i = '0;
  logic              done_o;
  logic              pred_taken_o;
  logic [31:0]       pred_target_o;
  logic [31:0]       branch_count_o;
  logic [31:0]       flush_count_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CfgIW-1:0]  cfg_index_i = CFG_BTB_INDEX_BITS;
  logic [CfgDW-1:0]  cfg_data_i = '0;

  btb_two_level_branch_predictor_core dut (.*);

  // queues between the stimulus, the driver and the checker
  branch_cmd_t pending_cmds[$];
  branch_res_t expected_res[$];
  int unsigned n_sent = 0;
  int unsigned n_errors = 0;

  // ---------------------------------------------------------------
  // predictor: own copy of the configuration and the tables
  // ---------------------------------------------------------------
  logic [2:0]  m_index_bits;
  logic [3:0]  m_hist_bits;
  logic [4:0]  m_tag_bits;
  logic [1:0]  m_default;
  logic        m_ghist;
  logic        m_gtable;
  logic [1:0]  m_share;
  logic        m_valid[32];
  logic [29:0] m_tag[32];
  logic [31:0] m_target[32];
  logic [7:0]  m_hist[32];
  logic [1:0]  m_row_ctr[32*256];
  logic [7:0]  m_shared_hist;
  logic [1:0]  m_shared_ctr[256];
  logic [31:0] m_branches;
  logic [31:0] m_flushes;

  task automatic predictor_reset();
    m_index_bits = 3'd0; m_hist_bits = 4'd1; m_tag_bits = 5'd0; m_default = CTR_RESET;
    m_ghist = 1'b0; m_gtable = 1'b0; m_share = SHARE_HIST;
    for (int i = 0; i < 32; i++) begin
      m_valid[i] = 1'b0; m_tag[i] = '0; m_target[i] = '0; m_hist[i] = '0;
    end
    for (int i = 0; i < 32*256; i++) m_row_ctr[i] = '0;
    for (int i = 0; i < 256; i++) m_shared_ctr[i] = CTR_RESET;
    m_shared_hist = '0; m_branches = '0; m_flushes = '0;
  endtask

  task automatic predictor_config(logic [CfgIW-1:0] idx, logic [CfgDW-1:0] val);
    case (idx)
      CFG_BTB_INDEX_BITS: m_index_bits = val[2:0];
      CFG_HISTORY_BITS:   m_hist_bits = val[3:0];
      CFG_TAG_BITS:       m_tag_bits = val[4:0];
      CFG_DEFAULT_STATE: begin
        m_default = val[1:0];
        for (int i = 0; i < 256; i++) m_shared_ctr[i] = m_default;
      end
      CFG_GLOBAL_HISTORY: m_ghist = val[0];
      CFG_GLOBAL_TABLE:   m_gtable = val[0];
      CFG_SHARE_MODE:     m_share = val[1:0];
      default: ;
    endcase
  endtask

  // works out the result of one accepted command and trains the tables
  task automatic predict_branch(branch_cmd_t c);
    int unsigned hw, hmask, entries, tb, slot, h, share, ci;
    logic [29:0] tag;
    logic [31:0] next_pc;
    logic [1:0]  ctr;
    branch_res_t r;
    hw = (m_hist_bits < 1) ? 1 : (m_hist_bits > 8) ? 8 : m_hist_bits;
    hmask = (1 << hw) - 1;
    entries = 1 << m_index_bits;
    if (entries > 32) entries = 32;
    tb = (m_tag_bits > TAG_BITS_MAX) ? TAG_BITS_MAX : m_tag_bits;
    tag = 30'((64'(c.pc) >> 2) & ((64'd1 << tb) - 1));
    slot = tag % entries;
    next_pc = c.pc + 32'd4;
    r = '{1'b0, 32'h0, 32'h0, 32'h0};
    if (c.action == ACT_PREDICT) begin
      r.pred_target = next_pc;
      if (m_valid[slot] && m_tag[slot] == tag) begin
        h = (m_ghist ? m_shared_hist : m_hist[slot]) & hmask;
        share = (m_share == SHARE_LOWPC) ? (c.pc >> 2) & hmask :
                (m_share == SHARE_PC16) ? (c.pc >> 16) & hmask : 0;
        ctr = m_gtable ? m_shared_ctr[(h ^ share) & hmask] : m_row_ctr[slot*256 + h];
        if (ctr >= CTR_TAKEN_THR) begin
          r.pred_taken = 1'b1;
          r.pred_target = m_target[slot];
        end
      end
    end else begin
      m_target[slot] = c.target_pc;
      if (!((c.taken && c.target_pc == c.predicted_target) ||
            (!c.taken && c.predicted_target == next_pc)))
        m_flushes++;
      // allocation on a miss or an empty entry
      if (!m_valid[slot] || m_tag[slot] != tag) begin
        m_tag[slot] = tag;
        m_valid[slot] = 1'b1;
        if (!m_ghist) m_hist[slot] = '0;
        if (!m_gtable) for (int i = 0; i < 256; i++) m_row_ctr[slot*256 + i] = m_default;
      end
      h = (m_ghist ? m_shared_hist : m_hist[slot]) & hmask;
      share = (m_share == SHARE_LOWPC) ? (c.pc >> 2) & hmask :
              (m_share == SHARE_PC16) ? (c.pc >> 16) & hmask : 0;
      ci = m_gtable ? ((h ^ share) & hmask) : slot*256 + h;
      ctr = m_gtable ? m_shared_ctr[ci] : m_row_ctr[ci];
      if (c.taken && ctr < CTR_MAX) ctr++;
      else if (!c.taken && ctr > CTR_MIN) ctr--;
      if (m_gtable) m_shared_ctr[ci] = ctr; else m_row_ctr[ci] = ctr;
      h = ((h << 1) | c.taken) & hmask;
      if (m_ghist) m_shared_hist = 8'(h); else m_hist[slot] = 8'(h);
      m_branches++;
    end
    r.branch_count = m_branches;
    r.flush_count = m_flushes;
    expected_res.push_back(r);
  endtask

  // ---------------------------------------------------------------
  // monitor: tracks transfers on all three channels and checks results
  // ---------------------------------------------------------------
  initial predictor_reset();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_res.size() == 0) begin
          $error("result with nothing expected");
          n_errors++;
        end else begin
          branch_res_t e;
          e = expected_res.pop_front();
          if (pred_taken_o !== e.pred_taken) begin
            $error("pred_taken exp %0h got %0h", e.pred_taken, pred_taken_o); n_errors++;
          end
          if (pred_target_o !== e.pred_target) begin
            $error("pred_target exp %0h got %0h", e.pred_target, pred_target_o); n_errors++;
          end
          if (branch_count_o !== e.branch_count) begin
            $error("branch_count exp %0h got %0h", e.branch_count, branch_count_o);
            n_errors++;
          end
          if (flush_count_o !== e.flush_count) begin
            $error("flush_count exp %0h got %0h", e.flush_count, flush_count_o);
            n_errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) predictor_config(cfg_index_i, cfg_data_i);
      if (start && !busy)
        predict_branch('{action_i, pc_i, target_pc_i, taken_i, predicted_target_i});
    end
  end

  // ---------------------------------------------------------------
  // driver: feeds commands from the pending queue, idling at random
  // ---------------------------------------------------------------
  always @(posedge clk_i) begin
    logic        hold;
    logic        quiet;
    branch_cmd_t c;
    if (rst_ni) begin
      hold = start && busy;
      if (start && !busy) n_sent++;
      // a long stretch without any idling
      quiet = (n_sent % 800) >= 300 && (n_sent % 800) < 550;
      if (!hold) begin
        if (pending_cmds.size() != 0 && (quiet || $urandom_range(99) >= 16)) begin
          c = pending_cmds.pop_front();
          start <= 1'b1;
          action_i <= c.action;
          pc_i <= c.pc;
          target_pc_i <= c.target_pc;
          taken_i <= c.taken;
          predicted_target_i <= c.predicted_target;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  int unsigned stall_cycles = 0;
  always @(posedge clk_i) begin
    if (start && !busy || done_o || cfg_valid_i && cfg_ready_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 5000) begin
      $display("** btb_two_level_branch_predictor_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------
  task automatic push_cmd(logic act, logic [31:0] pc, logic [31:0] tgt, logic tk,
                          logic [31:0] pdst);
    branch_cmd_t c;
    c = '{act, pc, tgt, tk, pdst};
    pending_cmds.push_back(c);
  endtask

  // sender pauses until every result is in, then the block settles
  task automatic drain();
    while (pending_cmds.size() != 0 || start || expected_res.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // back-to-back register transfers, valid held high across them
  task automatic write_cfg(logic [2:0] ib, logic [3:0] hb, logic [4:0] tb, logic [1:0] ds,
                           logic gh, logic gt, logic [1:0] sm);
    logic [CfgDW-1:0] vals[7];
    vals = '{5'(ib), 5'(hb), tb, 5'(ds), 5'(gh), 5'(gt), 5'(sm)};
    for (int i = 0; i < 7; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // mostly a small pool of branch addresses so entries hit and train
  task automatic random_cmds(int n);
    logic [31:0] pool[8];
    logic [31:0] pc, tgt, pdst;
    logic        tk;
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      pc = ($urandom_range(99) < 85) ? pool[$urandom_range(7)] : $urandom;
      tgt = ($urandom_range(3) == 0) ? $urandom : pool[$urandom_range(7)];
      tk = 1'($urandom_range(1));
      case ($urandom_range(2))
        0: pdst = tgt;
        1: pdst = pc + 32'd4;
        default: pdst = $urandom;
      endcase
      push_cmd(1'($urandom_range(1)), pc, tgt, tk, pdst);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset configuration, miss, allocate, hit, wrap of pc+4
    push_cmd(ACT_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0);
    push_cmd(ACT_UPDATE, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_cmd(ACT_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0);
    push_cmd(ACT_UPDATE, 32'h0, 32'h1234_5678, 1'b1, 32'h0);
    push_cmd(ACT_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0);
    push_cmd(ACT_UPDATE, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
    push_cmd(ACT_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_cmd(ACT_UPDATE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, 32'h0000_0003);
    push_cmd(ACT_UPDATE, 32'h5555_5554, 32'h5555_5555, 1'b0, 32'h5555_5558);
    push_cmd(ACT_PREDICT, 32'h5555_5554, 32'h0, 1'b0, 32'h0);
    drain();

    // per-entry tables first so no row is read before it is allocated
    write_cfg(3'd5, 4'd8, 5'd30, 2'd3, 1'b0, 1'b0, SHARE_HIST);
    push_cmd(ACT_UPDATE, 32'hFFFF_FFFC, 32'h8000_0000, 1'b1, 32'h8000_0000);
    push_cmd(ACT_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
    push_cmd(ACT_UPDATE, 32'hFFFF_FFFC, 32'h8000_0000, 1'b0, 32'h0);
    push_cmd(ACT_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
    random_cmds(170);
    drain();
    write_cfg(3'd0, 4'd1, 5'd0, 2'd0, 1'b1, 1'b0, SHARE_PC16);
    random_cmds(170);
    drain();
    write_cfg(3'd2, 4'd4, 5'd5, 2'd2, 1'b0, 1'b0, SHARE_LOWPC);
    random_cmds(170);
    drain();
    // out-of-range widths and index bits
    write_cfg(3'd7, 4'd15, 5'd31, 2'd1, 1'b1, 1'b0, 2'd3);
    random_cmds(170);
    drain();

    // shared counter table from here on
    write_cfg(3'd5, 4'd8, 5'd30, 2'd1, 1'b1, 1'b1, SHARE_PC16);
    random_cmds(170);
    drain();
    write_cfg(3'd3, 4'd3, 5'd6, 2'd0, 1'b0, 1'b1, SHARE_LOWPC);
    random_cmds(170);
    drain();
    write_cfg(3'd7, 4'd0, 5'd31, 2'd3, 1'b1, 1'b1, 2'd3);
    random_cmds(170);
    drain();
    write_cfg(3'd0, 4'd15, 5'd0, 2'd2, 1'b0, 1'b1, SHARE_HIST);
    random_cmds(170);
    drain();
    write_cfg(3'd4, 4'd6, 5'd8, 2'd2, 1'b1, 1'b1, SHARE_LOWPC);
    random_cmds(170);
    drain();

    repeat (10) @(posedge clk_i);
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("** btb_two_level_branch_predictor_core: PASSED **");
    end else begin
      $display("** btb_two_level_branch_predictor_core: FAILED **");
    end
    $finish;
  end

endmodule
